FILE: sv/kbc_pkg.sv
// ============================================================================
// kbc_pkg
// Shared types and constants for the AT keyboard controller core.
// ============================================================================
package kbc_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int RAM_DEPTH_DEF   = 32;

    // Event codes on the func field.
    localparam logic [2:0] FUNC_HOST_WR  = 3'd0;
    localparam logic [2:0] FUNC_HOST_RD  = 3'd1;
    localparam logic [2:0] FUNC_POLL     = 3'd2;
    localparam logic [2:0] FUNC_KBD_BYTE = 3'd3;
    localparam logic [2:0] FUNC_AUX_BYTE = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_MOUSE_SUPPORTED = 1'b0;
    localparam logic CFG_JUMPER_BYTE     = 1'b1;

    // Status register bits.
    localparam int ST_OFULL = 0;
    localparam int ST_IFULL = 1;
    localparam int ST_SYS   = 2;
    localparam int ST_MFULL = 5;
    localparam int ST_RTIME = 6;

    // Interrupt source codes.
    localparam logic [1:0] IRQ_NONE  = 2'd0;
    localparam logic [1:0] IRQ_KBD   = 2'd1;
    localparam logic [1:0] IRQ_MOUSE = 2'd2;

    // One staged byte with its source.
    typedef struct packed {
        logic       valid;
        logic       ctrl;
        logic       mouse;
        logic [7:0] data;
    } entry_t;

endpackage

FILE: sv/kbc_queue.sv
// ============================================================================
// kbc_queue
// Ring queue holding DEPTH-1 bytes with push, pop and clear.
// ============================================================================
module kbc_queue #(
    parameter int DEPTH = kbc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] push_data,
    input  logic       push_second,
    input  logic [7:0] second_data,
    input  logic       pop,
    input  logic       clear,
    output logic       empty,
    output logic       full,
    output logic [7:0] head_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]    store_reg [DEPTH];
    logic [AW-1:0] head_reg;
    logic [AW-1:0] tail_reg;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] tail_inc;

    // Pointer increments wrap at the depth.
    always_comb
    begin
        head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);
        tail_inc = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + AW'(1);
    end

    assign empty     = (head_reg == tail_reg);
    assign full      = (tail_inc == head_reg);
    assign head_data = store_reg[head_reg];

    // Pointers. A clear empties the ring first, then any push in the same
    // cycle lands in the first slot, and a second byte in the slot after it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else if (clear)
        begin
            head_reg <= '0;
            if (push && push_second)
                tail_reg <= AW'(2);
            else if (push)
                tail_reg <= AW'(1);
            else
                tail_reg <= '0;
        end
        else
        begin
            if (pop)
                head_reg <= head_inc;
            if (push && !full)
                tail_reg <= tail_inc;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (clear && push)
        begin
            store_reg[0] <= push_data;
            if (push_second)
                store_reg[1] <= second_data;
        end
        else if (!clear && push && !full)
            store_reg[tail_reg] <= push_data;
    end

endmodule

FILE: sv/keyboard_controller_8042_core.sv
// ============================================================================
// keyboard_controller_8042_core
// AT keyboard controller: host ports, poll ticks, device bytes, three queues.
// ============================================================================
// Each accepted item yields one result, taken into the result register or the skid.
// Throughput: one item per cycle while the skid is empty; all state updates in the accept cycle.
// The result register is guarded by a one-deep skid so the input is ready
// while a finished result waits. Reset restores the state registers to their
// power-on values at once; queue stores and the result and skid data are not cleared.
module keyboard_controller_8042_core #(
    parameter int QUEUE_DEPTH = kbc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] func,
    input  logic       port_is_command,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       irq1_level,
    output logic       irq12_level,
    output logic       a20_enable,
    output logic       cpu_reset_pulse,
    output logic       mouse_tx_valid,
    output logic [7:0] mouse_tx_data,
    output logic       kbd_scan_enable,
    output logic       mouse_scan_enable,
    output logic       queue_overflow
);
    import kbc_pkg::*;

    typedef struct packed {
        logic [7:0] rd;
        logic       irq1;
        logic       irq12;
        logic       a20;
        logic       rst_pulse;
        logic       tx_valid;
        logic [7:0] tx_data;
        logic       kscan;
        logic       mscan;
        logic       ovf;
    } result_t;

    // Configuration.
    logic       mouse_sup_reg;
    logic [7:0] jumper_reg;

    // Controller state.
    logic       expect_data_reg, expect_data_next;
    logic [7:0] last_cmd_reg, last_cmd_next;
    logic [7:0] status_reg, status_next;
    logic [7:0] ram_reg [32];
    logic [7:0] ob_reg, ob_next;
    entry_t     staged_reg, staged_next;
    entry_t     deferred_reg, deferred_next;
    logic [7:0] oport_reg, oport_next;
    logic [7:0] kcmd_reg, kcmd_next;
    logic       karg_reg, karg_next;
    logic [1:0] irqsrc_reg, irqsrc_next;
    logic       init_reg, init_next;
    logic       kscan_reg, kscan_next;
    logic       mscan_reg, mscan_next;
    logic       irq1_reg, irq1_next;
    logic       irq12_reg, irq12_next;

    // RAM write port.
    logic       ram_we;
    logic [4:0] ram_wa;
    logic [7:0] ram_wd;
    logic [7:0] ram0_cur;
    logic [7:0] ram0_next;

    // Queue controls.
    logic       rq_push, rq_pop, rq_clear, rq_empty, rq_full;
    logic [7:0] rq_wd, rq_head;
    logic       kq_push, kq_pop, kq_clear, kq_empty, kq_full, kq_second;
    logic [7:0] kq_wd, kq_head;
    logic       mq_push, mq_pop, mq_empty, mq_full;
    logic [7:0] mq_wd, mq_head;

    // Result skid.
    result_t res_now;
    result_t res_reg;
    result_t skid_reg;
    logic    res_vld_reg;
    logic    skid_vld_reg;
    logic    accept;
    logic    ovf;

    assign in_ready  = !skid_vld_reg;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;

    kbc_queue #(.DEPTH(QUEUE_DEPTH)) u_reply_q (
        .clk(clk), .rst_n(rst_n), .push(rq_push), .push_data(rq_wd),
        .push_second(1'b0), .second_data(8'h00), .pop(rq_pop),
        .clear(rq_clear), .empty(rq_empty), .full(rq_full), .head_data(rq_head)
    );
    kbc_queue #(.DEPTH(QUEUE_DEPTH)) u_key_q (
        .clk(clk), .rst_n(rst_n), .push(kq_push), .push_data(kq_wd),
        .push_second(kq_second), .second_data(8'haa), .pop(kq_pop),
        .clear(kq_clear), .empty(kq_empty), .full(kq_full), .head_data(kq_head)
    );
    kbc_queue #(.DEPTH(QUEUE_DEPTH)) u_mouse_q (
        .clk(clk), .rst_n(rst_n), .push(mq_push), .push_data(mq_wd),
        .push_second(1'b0), .second_data(8'h00), .pop(mq_pop),
        .clear(1'b0), .empty(mq_empty), .full(mq_full), .head_data(mq_head)
    );

    // Event decode: at most one RAM write, one push per queue per item (a keyboard reset push adds a second byte).
    always_comb
    begin
        logic [7:0] v;
        logic       do_reply;
        logic [7:0] reply_val;
        logic       rq_cleared;
        logic       rq_is_empty;
        logic       rq_is_full;
        v = data_byte;
        expect_data_next = expect_data_reg;
        last_cmd_next    = last_cmd_reg;
        status_next      = status_reg;
        ob_next          = ob_reg;
        staged_next      = staged_reg;
        deferred_next    = deferred_reg;
        oport_next       = oport_reg;
        kcmd_next        = kcmd_reg;
        karg_next        = karg_reg;
        irqsrc_next      = irqsrc_reg;
        init_next        = init_reg;
        kscan_next       = kscan_reg;
        mscan_next       = mscan_reg;
        irq1_next        = irq1_reg;
        irq12_next       = irq12_reg;
        ram0_cur         = ram_reg[0];
        ram0_next        = ram_reg[0];
        ram_we = 1'b0; ram_wa = '0; ram_wd = '0;
        rq_push = 1'b0; rq_pop = 1'b0; rq_clear = 1'b0; rq_wd = '0;
        kq_push = 1'b0; kq_pop = 1'b0; kq_clear = 1'b0; kq_wd = '0;
        kq_second = 1'b0;
        mq_push = 1'b0; mq_pop = 1'b0; mq_wd = '0;
        do_reply = 1'b0; reply_val = '0;
        rq_cleared = 1'b0; rq_is_empty = 1'b0; rq_is_full = 1'b0;
        res_now = '0;
        res_now.rd = 8'hff;
        ovf = 1'b0;

        if (accept)
        begin
            case (func)
                FUNC_HOST_WR:
                begin
                    if (port_is_command)
                    begin
                        expect_data_next = 1'b0;
                        last_cmd_next    = v;
                        if (v[7:5] == 3'b001)
                        begin
                            do_reply  = 1'b1;
                            reply_val = ram_reg[v[4:0]];
                        end
                        else if (v[7:5] == 3'b011)
                            expect_data_next = 1'b1;
                        else if (v[7:4] == 4'hf && !v[0])
                            res_now.rst_pulse = 1'b1;
                        else
                        begin
                            case (v)
                                8'ha7: mscan_next = 1'b0;
                                8'ha8: if (mouse_sup_reg) mscan_next = 1'b1;
                                8'ha9: if (mouse_sup_reg) do_reply = 1'b1;
                                8'haa:
                                begin
                                    if (!init_reg)
                                    begin
                                        init_next = 1'b1;
                                        rq_clear  = 1'b1;
                                        status_next[ST_OFULL] = 1'b0;
                                    end
                                    status_next[ST_SYS] = 1'b1;
                                    ram0_next[2] = 1'b1;
                                    do_reply  = 1'b1;
                                    reply_val = 8'h55;
                                    oport_next = 8'hcf;
                                end
                                8'hab: do_reply = 1'b1;
                                8'had: ram0_next[4] = 1'b1;
                                8'hae:
                                begin
                                    ram0_next[4] = 1'b0;
                                    if (!init_reg) do_reply = 1'b1;
                                end
                                8'hc0: begin do_reply = 1'b1; reply_val = jumper_reg; end
                                8'hd0: begin do_reply = 1'b1; reply_val = oport_reg; end
                                8'hd1: expect_data_next = 1'b1;
                                8'hd3, 8'hd4: if (mouse_sup_reg) expect_data_next = 1'b1;
                                8'he0: do_reply = 1'b1;
                                default: ;
                            endcase
                        end
                    end
                    else if (expect_data_reg)
                    begin
                        expect_data_next = 1'b0;
                        if (last_cmd_reg[7:5] == 3'b011)
                        begin
                            if (last_cmd_reg[4:0] == 5'd0)
                            begin
                                ram0_next  = v;
                                mscan_next = !v[5];
                            end
                            else
                            begin
                                ram_we = 1'b1;
                                ram_wa = last_cmd_reg[4:0];
                                ram_wd = v;
                            end
                        end
                        else if (last_cmd_reg == 8'hd1)
                            oport_next = v;
                        else if (last_cmd_reg == 8'hd3)
                        begin
                            if (mouse_sup_reg)
                            begin
                                mq_push = 1'b1; mq_wd = v; ovf = mq_full;
                            end
                        end
                        else if (last_cmd_reg == 8'hd4)
                        begin
                            if (mouse_sup_reg)
                            begin
                                res_now.tx_valid = 1'b1;
                                res_now.tx_data  = v;
                            end
                        end
                    end
                    else
                    begin
                        ram0_next[4] = 1'b0;
                        if (karg_reg)
                        begin
                            karg_next = 1'b0;
                            if (kcmd_reg == 8'hed || kcmd_reg == 8'hf3)
                            begin
                                kq_push = 1'b1; kq_wd = 8'hfa; ovf = kq_full;
                            end
                        end
                        else
                        begin
                            kcmd_next = v;
                            kq_push = 1'b1;
                            kq_wd   = 8'hfa;
                            ovf     = kq_full;
                            case (v)
                                8'hed, 8'hf3: karg_next = 1'b1;
                                8'hf2: ;
                                8'hf4: kscan_next = 1'b1;
                                8'hf5: kscan_next = 0;
                                8'hff:
                                begin
                                    // Empty the keyboard queue, then queue the
                                    // acknowledge and the self-test pass byte.
                                    kq_clear  = 1'b1;
                                    kq_second = 1'b1;
                                    ovf       = 1'b0;
                                end
                                default: kq_wd = 8'hfe;
                            endcase
                        end
                    end
                end
                FUNC_HOST_RD:
                begin
                    if (port_is_command)
                    begin
                        res_now.rd = {status_reg[7:3], ram0_cur[ST_SYS], status_reg[1:0]};
                        status_next[ST_RTIME] = 1'b0;
                    end
                    else
                    begin
                        res_now.rd = ob_reg;
                        status_next[ST_OFULL] = 1'b0;
                        if (irqsrc_reg == IRQ_KBD)
                            irq1_next = 1'b0;
                        else if (irqsrc_reg == IRQ_MOUSE)
                            irq12_next = 1'b0;
                        irqsrc_next = IRQ_NONE;
                    end
                end
                FUNC_POLL:
                begin
                    if (staged_reg.valid && irqsrc_reg == IRQ_NONE)
                    begin
                        ob_next = staged_reg.data;
                        status_next[ST_OFULL] = 1'b1;
                        status_next[ST_IFULL] = 1'b0;
                        if (staged_reg.mouse)
                        begin
                            if (ram0_cur[1]) irq12_next = 1'b1;
                            status_next[ST_MFULL] = 1'b1;
                            irqsrc_next = IRQ_MOUSE;
                        end
                        else
                        begin
                            if (ram0_cur[0]) irq1_next = 1'b1;
                            status_next[ST_MFULL] = 1'b0;
                            irqsrc_next = IRQ_KBD;
                        end
                        staged_next = '0;
                    end
                    if (!staged_next.valid && !status_next[ST_OFULL])
                    begin
                        if (!rq_empty)
                        begin
                            rq_pop = 1'b1;
                            staged_next = '{valid: 1'b1, ctrl: 1'b1, mouse: 1'b0,
                                            data: rq_head};
                        end
                        else if (deferred_reg.valid)
                        begin
                            staged_next   = deferred_reg;
                            deferred_next = '0;
                        end
                        else if (!mq_empty)
                        begin
                            mq_pop = 1'b1;
                            staged_next = '{valid: 1'b1, ctrl: 1'b0, mouse: 1'b1,
                                            data: mq_head};
                        end
                        else if (!ram0_cur[4] && !kq_empty)
                        begin
                            kq_pop = 1'b1;
                            staged_next = '{valid: 1'b1, ctrl: 1'b0, mouse: 1'b0,
                                            data: kq_head};
                        end
                    end
                end
                FUNC_KBD_BYTE:
                begin
                    kq_push = 1'b1; kq_wd = v; ovf = kq_full;
                end
                FUNC_AUX_BYTE:
                begin
                    mq_push = 1'b1; mq_wd = v; ovf = mq_full;
                end
                default: ;
            endcase

            // Controller reply: queue it and step a staged keyboard byte aside.
            if (do_reply)
            begin
                rq_cleared  = rq_clear;
                rq_is_empty = rq_cleared || rq_empty;
                rq_is_full  = !rq_cleared && rq_full;
                rq_push = 1'b1;
                rq_wd   = reply_val;
                ovf     = rq_is_full && !rq_is_empty;
                if (staged_reg.valid && !staged_reg.ctrl && !staged_reg.mouse)
                begin
                    deferred_next = staged_reg;
                    staged_next   = '0;
                end
            end
        end

        res_now.irq1  = irq1_next;
        res_now.irq12 = irq12_next;
        res_now.a20   = oport_next[1];
        res_now.kscan = kscan_next;
        res_now.mscan = mscan_next;
        res_now.ovf   = ovf;
    end

    // Controller RAM: entry 0 has its own update path.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                ram_reg[i] <= (i == 0) ? 8'h11 : 8'h00;
        end
        else
        begin
            ram_reg[0] <= ram0_next;
            if (ram_we)
                ram_reg[ram_wa] <= ram_wd;
        end
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mouse_sup_reg   <= 1'b1;
            jumper_reg      <= 8'h00;
            expect_data_reg <= 1'b0;
            last_cmd_reg    <= 8'h00;
            status_reg      <= 8'h18;
            ob_reg          <= 8'h00;
            staged_reg      <= '0;
            deferred_reg    <= '0;
            oport_reg       <= 8'hcf;
            kcmd_reg        <= 8'h00;
            karg_reg        <= 1'b0;
            irqsrc_reg      <= IRQ_NONE;
            init_reg        <= 1'b0;
            kscan_reg       <= 1'b1;
            mscan_reg       <= 1'b0;
            irq1_reg        <= 1'b0;
            irq12_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_MOUSE_SUPPORTED)
                    mouse_sup_reg <= cfg_data[0];
                else
                    jumper_reg <= cfg_data;
            end
            expect_data_reg <= expect_data_next;
            last_cmd_reg    <= last_cmd_next;
            status_reg      <= status_next;
            ob_reg          <= ob_next;
            staged_reg      <= staged_next;
            deferred_reg    <= deferred_next;
            oport_reg       <= oport_next;
            kcmd_reg        <= kcmd_next;
            karg_reg        <= karg_next;
            irqsrc_reg      <= irqsrc_next;
            init_reg        <= init_next;
            kscan_reg       <= kscan_next;
            mscan_reg       <= mscan_next;
            irq1_reg        <= irq1_next;
            irq12_reg       <= irq12_next;
        end
    end

    // Result register with skid stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (!res_vld_reg || out_ready)
            begin
                if (skid_vld_reg)
                begin
                    res_vld_reg  <= 1'b1;
                    skid_vld_reg <= accept;
                end
                else
                    res_vld_reg <= accept;
            end
            else if (accept)
                skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!res_vld_reg || out_ready)
        begin
            if (skid_vld_reg)
            begin
                res_reg <= skid_reg;
                if (accept) skid_reg <= res_now;
            end
            else if (accept)
                res_reg <= res_now;
        end
        else if (accept)
            skid_reg <= res_now;
    end

    assign out_valid         = res_vld_reg;
    assign read_data         = res_reg.rd;
    assign irq1_level        = res_reg.irq1;
    assign irq12_level       = res_reg.irq12;
    assign a20_enable        = res_reg.a20;
    assign cpu_reset_pulse   = res_reg.rst_pulse;
    assign mouse_tx_valid    = res_reg.tx_valid;
    assign mouse_tx_data     = res_reg.tx_data;
    assign kbd_scan_enable   = res_reg.kscan;
    assign mouse_scan_enable = res_reg.mscan;
    assign queue_overflow    = res_reg.ovf;

endmodule
